>>> design/cjs_pkg.sv
`timescale 1ns / 1ps

package cjs_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_CNT_W = 5;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_PUSHED_NEW = 3'd0,
        ST_PUSHED_DUP = 3'd1,
        ST_POPPED     = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef struct packed {
        logic [3:0]  job_type;
        logic [31:0] key;
        logic [2:0]  mode;
    } entry_t;

    typedef struct packed {
        logic load_new;
        logic shift;
        logic clr;
        logic is_top;
    } cell_ctrl_t;

endpackage

>>> design/cjs_cell.sv
`timescale 1ns / 1ps

module cjs_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  cjs_pkg::cell_ctrl_t ctrl,
    input  cjs_pkg::entry_t     new_entry,
    input  cjs_pkg::entry_t     above_entry,
    input  logic [3:0]          match_type,
    input  logic [31:0]         match_key,
    input  logic                match_in,
    input  logic [2:0]          mode_in,
    input  cjs_pkg::entry_t     pop_in,
    output cjs_pkg::entry_t     entry_q,
    output logic                match_out,
    output logic [2:0]          mode_out,
    output cjs_pkg::entry_t     pop_out
);

    cjs_pkg::entry_t entry_reg;
    logic            valid_reg;
    logic            hit;

    assign entry_q = entry_reg;

    assign hit = valid_reg && (match_key != 32'd0) && (entry_reg.key == match_key)
                 && (entry_reg.job_type == match_type);

    assign match_out = match_in | hit;
    assign mode_out  = mode_in | (hit ? entry_reg.mode : 3'd0);
    assign pop_out   = ctrl.is_top ? entry_reg : pop_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load_new)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctrl.clr)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_new)
        begin
            entry_reg <= new_entry;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= above_entry;
        end
    end

endmodule

>>> design/coalescing_job_stack_top.sv
`timescale 1ns / 1ps

// Job stack with duplicate coalescing. Requests arrive as beats on the s_axis
// channel: tuser selects push or pop, tdata carries the job. Each request gives
// exactly one result beat on the m_axis channel, with the status in tuser and
// the popped job and the entry count in tdata.
// A request is accepted and every cell of the stack compares its entry in parallel
// and shifts or loads at the accepting edge; the result is loaded into the output
// register at that same edge. Throughput is one request per cycle while the receiver
// takes each result, since the whole cell row updates at the accepting edge.
// A push whose type and nonzero key match a held entry removes that entry and
// puts the job on top with the lower of the two modes. A push of a new job to
// a full stack is rejected. A pop of an empty stack reports empty.
// Reset empties the stack and the output register at once. When the receiver
// stalls, the result waits in the output register; one more request can be
// accepted only in the cycle in which that result is taken.
module coalescing_job_stack_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // job_type[3:0], descriptor_key[35:4], convert_mode[38:36], zero pad.
    input  logic [39:0] s_axis_tdata,
    // action[0].
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_type[3:0], out_descriptor[35:4], out_mode[38:36], entry_count[43:39],
    // zero pad.
    output logic [47:0] m_axis_tdata,
    // status[2:0].
    output logic [2:0]  m_axis_tuser
);

    localparam int DEPTH = cjs_pkg::STACK_DEPTH;
    localparam int CW    = cjs_pkg::CNT_W;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                out_valid_reg;
    logic [47:0]         out_data_reg;
    logic [47:0]         out_data_next;
    cjs_pkg::status_t    out_status_reg;
    cjs_pkg::status_t    out_status_next;

    logic                accept;
    logic                is_pop;
    logic                dup;
    logic                full;
    logic                empty;
    logic                push_ok;
    logic [CW-1:0]       write_idx;
    logic [CW-1:0]       top_idx;
    logic [2:0]          merged_mode;
    cjs_pkg::entry_t     new_entry;
    cjs_pkg::entry_t     pop_entry;

    cjs_pkg::entry_t     cell_q     [DEPTH];
    cjs_pkg::entry_t     above      [DEPTH];
    cjs_pkg::cell_ctrl_t ctrl       [DEPTH];
    logic [DEPTH:0]      match_chain;
    logic [2:0]          mode_chain [DEPTH+1];
    cjs_pkg::entry_t     pop_chain  [DEPTH+1];

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    assign is_pop  = (s_axis_tuser == cjs_pkg::ACT_POP);
    assign dup     = match_chain[DEPTH];
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = !is_pop && (dup || !full);
    assign top_idx = count_reg - CW'(1);
    assign write_idx = dup ? top_idx : count_reg;

    assign merged_mode = (dup && (mode_chain[DEPTH] < s_axis_tdata[38:36]))
                         ? mode_chain[DEPTH] : s_axis_tdata[38:36];

    assign new_entry.job_type = s_axis_tdata[3:0];
    assign new_entry.key      = s_axis_tdata[35:4];
    assign new_entry.mode     = merged_mode;

    assign match_chain[0] = 1'b0;
    assign mode_chain[0]  = 3'd0;
    assign pop_chain[0]   = '0;
    assign pop_entry      = pop_chain[DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_last
            assign above[i] = '0;
        end
        else
        begin : g_mid
            assign above[i] = cell_q[i+1];
        end

        assign ctrl[i].is_top   = (CW'(i) == top_idx);
        assign ctrl[i].load_new = accept && push_ok && (CW'(i) == write_idx);
        assign ctrl[i].shift    = accept && push_ok && dup && match_chain[i+1]
                                  && (CW'(i) < write_idx);
        assign ctrl[i].clr      = accept && is_pop && !empty && (CW'(i) == top_idx);

        cjs_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl[i]),
            .new_entry   (new_entry),
            .above_entry (above[i]),
            .match_type  (s_axis_tdata[3:0]),
            .match_key   (s_axis_tdata[35:4]),
            .match_in    (match_chain[i]),
            .mode_in     (mode_chain[i]),
            .pop_in      (pop_chain[i]),
            .entry_q     (cell_q[i]),
            .match_out   (match_chain[i+1]),
            .mode_out    (mode_chain[i+1]),
            .pop_out     (pop_chain[i+1])
        );
    end

    always_comb
    begin
        count_next      = count_reg;
        out_status_next = cjs_pkg::ST_PUSHED_NEW;
        out_data_next   = '0;
        if (is_pop)
        begin
            if (empty)
            begin
                out_status_next = cjs_pkg::ST_EMPTY;
            end
            else
            begin
                out_status_next      = cjs_pkg::ST_POPPED;
                count_next           = top_idx;
                out_data_next[3:0]   = pop_entry.job_type;
                out_data_next[35:4]  = pop_entry.key;
                out_data_next[38:36] = pop_entry.mode;
            end
        end
        else if (dup)
        begin
            out_status_next = cjs_pkg::ST_PUSHED_DUP;
        end
        else if (full)
        begin
            out_status_next = cjs_pkg::ST_FULL;
        end
        else
        begin
            out_status_next = cjs_pkg::ST_PUSHED_NEW;
            count_next      = count_reg + CW'(1);
        end
        out_data_next[43:39] = cjs_pkg::ENTRY_CNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

>>> tb/sv/coalescing_job_stack_checker.sv
`timescale 1ns / 1ps

module coalescing_job_stack_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // job_type[3:0], descriptor_key[35:4], convert_mode[38:36], zero pad.
    input  logic [39:0] s_axis_tdata,
    // action[0].
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_type[3:0], out_descriptor[35:4], out_mode[38:36], entry_count[43:39],
    // zero pad.
    input  logic [47:0] m_axis_tdata,
    // status[2:0].
    input  logic [2:0]  m_axis_tuser,
    output int          error_count,
    output int          pending_count
);

    typedef struct {
        cjs_pkg::status_t                status;
        logic [3:0]                      job_type;
        logic [31:0]                     key;
        logic [2:0]                      mode;
        logic [cjs_pkg::ENTRY_CNT_W-1:0] count;
    } reply_t;

    cjs_pkg::entry_t jobs [cjs_pkg::STACK_DEPTH];
    int              held_jobs;
    reply_t          expected_replies [$];

    assign pending_count = expected_replies.size();

    task automatic predict_reply(input logic act, input logic [3:0] ty,
                                 input logic [31:0] key, input logic [2:0] mode);
        reply_t     r;
        int         n;
        int         i;
        int         j;
        logic       dup;
        logic [2:0] m;
        n        = held_jobs;
        dup      = 1'b0;
        m        = mode;
        r.job_type = '0;
        r.key      = '0;
        r.mode     = '0;
        if (act == cjs_pkg::ACT_POP)
        begin
            if (n == 0)
            begin
                r.status = cjs_pkg::ST_EMPTY;
            end
            else
            begin
                r.status   = cjs_pkg::ST_POPPED;
                r.job_type = jobs[n - 1].job_type;
                r.key      = jobs[n - 1].key;
                r.mode     = jobs[n - 1].mode;
                n--;
            end
        end
        else
        begin
            // A zero key stands for no descriptor and never coalesces.
            if (key != 32'd0)
            begin
                for (i = n - 1; i >= 0; i--)
                begin
                    if (!dup && jobs[i].job_type == ty && jobs[i].key == key)
                    begin
                        if (jobs[i].mode < m)
                            m = jobs[i].mode;
                        for (j = i; j < n - 1; j++)
                            jobs[j] = jobs[j + 1];
                        n--;
                        dup = 1'b1;
                    end
                end
            end
            if (!dup && n >= cjs_pkg::STACK_DEPTH)
            begin
                r.status = cjs_pkg::ST_FULL;
            end
            else
            begin
                jobs[n].job_type = ty;
                jobs[n].key      = key;
                jobs[n].mode     = m;
                n++;
                r.status = dup ? cjs_pkg::ST_PUSHED_DUP : cjs_pkg::ST_PUSHED_NEW;
            end
        end
        held_jobs = n;
        r.count   = n[cjs_pkg::ENTRY_CNT_W-1:0];
        expected_replies.push_back(r);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    initial error_count = 0;

    always @(posedge clk or negedge rst_n)
    begin : monitor
        reply_t want;
        if (!rst_n)
        begin
            held_jobs = 0;
            expected_replies.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %0h/%0h",
                             $time, m_axis_tuser, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_axis_tuser));
                    compare_field("out_type", 32'(want.job_type), 32'(m_axis_tdata[3:0]));
                    compare_field("out_descriptor", want.key, m_axis_tdata[35:4]);
                    compare_field("out_mode", 32'(want.mode), 32'(m_axis_tdata[38:36]));
                    compare_field("entry_count", 32'(want.count), 32'(m_axis_tdata[43:39]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_reply(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[35:4],
                              s_axis_tdata[38:36]);
        end
    end

endmodule

>>> tb/sv/coalescing_job_stack_top_tb.sv
`timescale 1ns / 1ps

module coalescing_job_stack_top_tb;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    int          error_count;
    int          pending_count;

    int          burst_left;
    logic [31:0] key_pool [8];
    logic [3:0]  type_pool [3];

    coalescing_job_stack_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    coalescing_job_stack_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always #10 clk = ~clk;

    task automatic send_request(input logic act, input logic [3:0] ty,
                                input logic [31:0] key, input logic [2:0] mode);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {1'b0, mode, key, ty};
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        @(posedge clk);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = cjs_pkg::ACT_PUSH;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int cyc;
        int mode;
        int stretch;
        bit hold_done;
        cyc           = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 60);
            repeat (stretch)
            begin
                @(posedge clk);
                cyc++;
                // One long hold-off lets the output register fill and back up the input.
                if (!hold_done && cyc >= 600)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (200) @(posedge clk);
                    cyc += 200;
                    hold_done = 1'b1;
                end
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 4) != 0);
                    default: m_axis_tready <= (cyc % 4 == 0);
                endcase
            end
        end
    end

    initial
    begin
        int          sent;
        int          push_pct;
        int          phase_len;
        int          j;
        int          pick;
        logic        act;
        logic [3:0]  ty;
        logic [31:0] key;
        burst_left = $urandom_range(1, 30);
        for (j = 0; j < 8; j++)
            key_pool[j] = $urandom;
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'h0000_0001;
        for (j = 0; j < 3; j++)
            type_pool[j] = 4'($urandom_range(0, 15));
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        send_request(cjs_pkg::ACT_POP, 4'hF, 32'hFFFF_FFFF, 3'd7);
        send_request(cjs_pkg::ACT_PUSH, 4'h0, 32'h0, 3'd0);
        send_request(cjs_pkg::ACT_PUSH, 4'h0, 32'h0, 3'd7);
        send_request(cjs_pkg::ACT_PUSH, 4'hF, 32'hFFFF_FFFF, 3'd7);
        send_request(cjs_pkg::ACT_PUSH, 4'hF, 32'hFFFF_FFFF, 3'd3);
        send_request(cjs_pkg::ACT_PUSH, 4'hF, 32'hFFFF_FFFF, 3'd5);
        send_request(cjs_pkg::ACT_PUSH, 4'hE, 32'hFFFF_FFFF, 3'd2);
        send_request(cjs_pkg::ACT_POP, 4'h0, 32'h0, 3'd0);
        send_request(cjs_pkg::ACT_POP, 4'h5, 32'hA5A5_5A5A, 3'd4);
        for (j = 0; j < 14; j++)
            send_request(cjs_pkg::ACT_PUSH, j[3:0], 32'h100 + j, j[2:0]);
        send_request(cjs_pkg::ACT_PUSH, 4'h1, 32'h555, 3'd1);
        send_request(cjs_pkg::ACT_PUSH, 4'h0, 32'h100, 3'd7);
        send_request(cjs_pkg::ACT_PUSH, 4'h3, 32'h0, 3'd6);
        drain_replies();

        sent = 0;
        while (sent < 750)
        begin
            pick      = $urandom_range(0, 2);
            push_pct  = (pick == 0) ? 85 : (pick == 1) ? 50 : 20;
            phase_len = $urandom_range(20, 80);
            for (j = 0; j < phase_len && sent < 750; j++)
            begin
                act  = ($urandom_range(0, 99) < push_pct) ? cjs_pkg::ACT_PUSH
                                                          : cjs_pkg::ACT_POP;
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    ty  = type_pool[$urandom_range(0, 2)];
                    key = key_pool[$urandom_range(0, 7)];
                end
                else if (pick < 8)
                begin
                    ty  = 4'($urandom_range(0, 15));
                    key = $urandom;
                end
                else if (pick == 8)
                begin
                    ty  = type_pool[$urandom_range(0, 2)];
                    key = 32'h0;
                end
                else
                begin
                    ty  = 4'($urandom_range(0, 15));
                    key = key_pool[$urandom_range(0, 7)];
                end
                send_request(act, ty, key, 3'($urandom_range(0, 7)));
                sent++;
                if (sent == 375)
                    drain_replies();
            end
        end

        drain_replies();
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
